// File: hdl/fermat_primality_witness_check_core_defines.svh
// Assertion macros used by the core RTL file.
`ifndef FERMAT_PRIMALITY_WITNESS_CHECK_CORE_DEFINES_SVH
`define FERMAT_PRIMALITY_WITNESS_CHECK_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define FPW_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define FPW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FPW_ASSERT(label, clk, rstn, prop, msg)
`define FPW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hdl/fpw_pkg.sv
package fpw_pkg;
  localparam int unsigned NumberBitsDefault = 32;
  localparam int unsigned FieldBits = 32;
  localparam int unsigned VerdictBits = 3;

  typedef enum logic [VerdictBits-1:0] {
    VerdictSmallComposite = 3'd0,
    VerdictSmallPrime     = 3'd1,
    VerdictCommonFactor   = 3'd2,
    VerdictFermatFails    = 3'd3,
    VerdictPasses         = 3'd4
  } verdict_e;

  // Command from the sequencer to the shared modular multiplier.
  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;
endpackage

// File: hdl/fpw_if.sv
interface fpw_in_if;
  import fpw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FieldBits-1:0] number;
  logic [FieldBits-1:0] witness;
  modport source (output valid, number, witness, input ready);
  modport sink   (input valid, number, witness, output ready);
endinterface

interface fpw_out_if;
  import fpw_pkg::*;
  logic     valid;
  logic     ready;
  verdict_e verdict;
  logic     probably_prime;
  modport source (output valid, verdict, probably_prime, input ready);
  modport sink   (input valid, verdict, probably_prime, output ready);
endinterface

// File: hdl/fermat_primality_witness_check_core.sv
// Flow: numbers up to 4 get their verdict straight after acceptance; otherwise the binary
// gcd runs first, then the bit-serial multiplier does one reduction of the witness, then a
// square per exponent bit, with a multiply ahead of it when that exponent bit is set.
// One transaction at a time: a new one is taken only after the result has been accepted.
// Reset: rst_ni is asynchronous and active low; it idles the sequencer and empties
// the result register.
`include "fermat_primality_witness_check_core_defines.svh"
module fermat_primality_witness_check_core
  import fpw_pkg::*;
#(
  parameter int unsigned NumberBits = NumberBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpw_in_if.sink     in_i,
  fpw_out_if.source  out_o
);
  localparam int unsigned CntBits = $clog2(NumberBits + 1);
  localparam logic [2:0] StIdle = 3'd0, StGcd = 3'd1, StRed = 3'd2, StMul = 3'd3,
                         StSqr = 3'd4, StOut = 3'd5;

  logic [2:0]            st_q, st_d;
  logic [NumberBits-1:0] n_q, n_d, w_q, w_d, e_q, e_d, base_q, base_d, acc_q, acc_d;
  logic [CntBits-1:0]    bit_q, bit_d;
  verdict_e              ver_q, ver_d;
  logic                  ov_q, ov_d, gcd_start;
  mul_ctrl_t             mctl;
  mul_stat_t             mst;
  logic [NumberBits-1:0] ma, mb, mp;
  logic                  gdone, gcop;
  logic [NumberBits-1:0] nin, win;

  assign nin = in_i.number[NumberBits-1:0];
  assign win = in_i.witness[NumberBits-1:0];
  assign in_i.ready = (st_q == StIdle) && !ov_q;

  fpw_gcd #(.NumberBits(NumberBits)) u_gcd (
    .clk_i, .rst_ni, .start_i(gcd_start), .x_i(n_q), .y_i(w_q),
    .done_o(gdone), .coprime_o(gcop)
  );

  fpw_modmul #(.NumberBits(NumberBits)) u_mul (
    .clk_i, .rst_ni, .ctrl_i(mctl), .a_i(ma), .b_i(mb), .m_i(n_q),
    .p_o(mp), .stat_o(mst)
  );

  // Sequencer: gcd, base reduction, then right-to-left square and multiply.
  always_comb begin
    st_d = st_q; n_d = n_q; w_d = w_q; e_d = e_q; base_d = base_q; acc_d = acc_q;
    bit_d = bit_q; ver_d = ver_q; ov_d = ov_q;
    gcd_start = 1'b0; mctl.start = 1'b0; ma = base_q; mb = base_q;
    if (out_o.valid && out_o.ready) ov_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_i.valid && in_i.ready) begin
          n_d = nin; w_d = win; e_d = nin - 1'b1;
          if (nin <= NumberBits'(1) || nin == NumberBits'(4)) begin
            ver_d = VerdictSmallComposite; st_d = StOut;
          end else if (nin <= NumberBits'(3)) begin
            ver_d = VerdictSmallPrime; st_d = StOut;
          end else begin
            st_d = StGcd;
            gcd_start = 1'b0;
          end
        end
      end
      StGcd: begin
        if (!mst.busy && !gdone && bit_q == '0) begin
          gcd_start = 1'b1; bit_d = CntBits'(1);
        end else if (gdone) begin
          bit_d = '0;
          if (!gcop) begin
            ver_d = VerdictCommonFactor; st_d = StOut;
          end else begin
            // The witness is fed through the multiplier bits, so it is reduced
            // one bit at a time whatever its size.
            ma = NumberBits'(1); mb = w_q; mctl.start = 1'b1; st_d = StRed;
          end
        end
      end
      StRed: begin
        if (mst.done) begin
          base_d = mp; acc_d = NumberBits'(1); bit_d = CntBits'(NumberBits);
          ma = acc_q; mb = mp; mctl.start = 1'b0;
          st_d = StMul;
        end
      end
      StMul: begin
        if (!mst.busy && !mst.done) begin
          if (bit_q == '0) begin
            ver_d = (acc_q == NumberBits'(1)) ? VerdictPasses : VerdictFermatFails;
            st_d = StOut;
          end else if (e_q[0]) begin
            ma = acc_q; mb = base_q; mctl.start = 1'b1;
          end else begin
            ma = base_q; mb = base_q; mctl.start = 1'b1; st_d = StSqr;
          end
        end else if (mst.done) begin
          acc_d = mp;
          ma = base_q; mb = base_q; mctl.start = 1'b1; st_d = StSqr;
        end
      end
      StSqr: begin
        if (mst.done) begin
          base_d = mp; e_d = e_q >> 1; bit_d = bit_q - 1'b1; st_d = StMul;
        end
      end
      StOut: begin
        if (!ov_q) begin
          ov_d = 1'b1; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      ov_q  <= 1'b0;
      bit_q <= '0;
    end else begin
      st_q  <= st_d;
      ov_q  <= ov_d;
      bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; w_q <= w_d; e_q <= e_d; base_q <= base_d; acc_q <= acc_d; ver_q <= ver_d;
  end

  assign out_o.valid          = ov_q;
  assign out_o.verdict        = ver_q;
  assign out_o.probably_prime = (ver_q == VerdictSmallPrime) || (ver_q == VerdictPasses);

  `FPW_ASSERT(a_no_accept_busy, clk_i, rst_ni, (st_q != StIdle) |-> !in_i.ready, "ready while busy")
  `FPW_ASSERT(a_out_hold, clk_i, rst_ni, (out_o.valid && !out_o.ready) |=> $stable(out_o.verdict), "result changed while stalled")
  `FPW_ASSERT(a_mul_idle_start, clk_i, rst_ni, mctl.start |-> !mst.busy, "multiplier restarted while busy")
endmodule

// File: hdl/fpw_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Also serves as a bit-serial remainder unit when a is one (b is then reduced).
module fpw_modmul
  import fpw_pkg::*;
#(
  parameter int unsigned NumberBits = NumberBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mul_ctrl_t             ctrl_i,
  input  logic [NumberBits-1:0] a_i,
  input  logic [NumberBits-1:0] b_i,
  input  logic [NumberBits-1:0] m_i,
  output logic [NumberBits-1:0] p_o,
  output mul_stat_t             stat_o
);
  localparam int unsigned CntBits = $clog2(NumberBits + 1);

  logic [NumberBits-1:0] acc_q, acc_d, a_q, a_d, b_q, b_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [NumberBits+1:0] dbl, dbl_r, add, add_r;

  // One step: acc = (2*acc + bit*a) mod m, two conditional subtractions.
  always_comb begin
    dbl   = {1'b0, acc_q, 1'b0};
    dbl_r = (dbl >= {2'b00, m_i}) ? dbl - {2'b00, m_i} : dbl;
    add   = dbl_r + (b_q[NumberBits-1] ? {2'b00, a_q} : '0);
    add_r = (add >= {2'b00, m_i}) ? add - {2'b00, m_i} : add;
  end

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = CntBits'(NumberBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = add_r[NumberBits-1:0];
      b_d   = {b_q[NumberBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign p_o         = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

// File: hdl/fpw_gcd.sv
// Binary gcd: one shift or one subtract-and-halve step per cycle; reports whether gcd is one.
module fpw_gcd
  import fpw_pkg::*;
#(
  parameter int unsigned NumberBits = NumberBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NumberBits-1:0] x_i,
  input  logic [NumberBits-1:0] y_i,
  output logic                  done_o,
  output logic                  coprime_o
);
  logic [NumberBits-1:0] x_q, x_d, y_q, y_d;
  logic                  busy_q, busy_d, done_q, done_d, cop_q, cop_d, even_q, even_d;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cop_d  = cop_q;
    even_d = even_q;
    if (start_i) begin
      x_d    = x_i;
      y_d    = y_i;
      busy_d = 1'b1;
      even_d = 1'b0;
    end else if (busy_q) begin
      priority if (y_q == '0) begin
        // gcd is x shifted back by any common power of two.
        busy_d = 1'b0;
        done_d = 1'b1;
        cop_d  = !even_q && (x_q == NumberBits'(1));
      end else if (!x_q[0] && !y_q[0]) begin
        even_d = 1'b1;
        x_d    = x_q >> 1;
        y_d    = y_q >> 1;
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q >= y_q) begin
        x_d = y_q;
        y_d = (x_q - y_q) >> 1;
      end else begin
        y_d = (y_q - x_q) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cop_q  <= 1'b0;
      even_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cop_q  <= cop_d;
      even_q <= even_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign done_o    = done_q;
  assign coprime_o = cop_q;
endmodule

// File: verif/fermat_primality_witness_check_core_test.sv
module fermat_primality_witness_check_core_test;
  import fpw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 120;
  localparam int unsigned DrainCycles = 2500;
  localparam longint unsigned CycleLimit = 3000000;

  // Verdict and flag that one transaction on the result channel carries.
  typedef struct {
    verdict_e verdict;
    logic     probably_prime;
  } verdict_rec_t;

  // One row of the directed stimulus; a typed-in verdict is used when known_verdict is set.
  typedef struct {
    logic [FieldBits-1:0] number;
    logic [FieldBits-1:0] witness;
    bit                   known_verdict;
    verdict_e             verdict;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fpw_in_if  in_bus ();
  fpw_out_if out_bus ();

  fermat_primality_witness_check_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  verdict_rec_t pending_verdicts[$];
  int unsigned  error_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  longint unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  // Euclid's gcd on 64-bit values.
  function automatic longint unsigned gcd_u64(longint unsigned p, longint unsigned q);
    longint unsigned rem;
    while (q != 0) begin
      rem = p % q;
      p = q;
      q = rem;
    end
    return p;
  endfunction

  // Square-and-multiply modular exponentiation; modulus stays below 2^32.
  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned expo,
                                              longint unsigned modulus);
    longint unsigned acc;
    acc = 1 % modulus;
    base = base % modulus;
    while (expo != 0) begin
      if (expo[0]) acc = (acc * base) % modulus;
      expo = expo >> 1;
      base = (base * base) % modulus;
    end
    return acc;
  endfunction

  // Single Fermat round with the small-number rules first.
  function automatic verdict_rec_t fermat_verdict(logic [FieldBits-1:0] number,
                                                  logic [FieldBits-1:0] witness);
    verdict_rec_t    rec;
    longint unsigned n;
    longint unsigned w;
    n = longint'(number);
    w = longint'(witness);
    if (n <= 1 || n == 4) rec.verdict = VerdictSmallComposite;
    else if (n <= 3) rec.verdict = VerdictSmallPrime;
    else if (gcd_u64(n, w) != 1) rec.verdict = VerdictCommonFactor;
    else if (pow_mod(w, n - 1, n) != 1) rec.verdict = VerdictFermatFails;
    else rec.verdict = VerdictPasses;
    rec.probably_prime = (rec.verdict == VerdictSmallPrime || rec.verdict == VerdictPasses);
    return rec;
  endfunction

  // Drive one input transaction, with optional idle cycles ahead of it.
  task automatic send_candidate(logic [FieldBits-1:0] number, logic [FieldBits-1:0] witness,
                                verdict_rec_t expected);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid   <= 1'b1;
    in_bus.number  <= number;
    in_bus.witness <= witness;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    pending_verdicts.push_back(expected);
  endtask

  // The receiver stalls at random and checks each result transaction.
  always @(negedge clk_i) begin
    if (rst_ni) out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result verdict=%0d prime=%0b", $realtime,
                 out_bus.verdict, out_bus.probably_prime);
        error_count++;
      end else begin
        verdict_rec_t exp_rec;
        exp_rec = pending_verdicts.pop_front();
        if (out_bus.verdict !== exp_rec.verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $realtime, exp_rec.verdict,
                   out_bus.verdict);
          error_count++;
        end
        if (out_bus.probably_prime !== exp_rec.probably_prime) begin
          $display("%0t: probably_prime expected %0b actual %0b", $realtime,
                   exp_rec.probably_prime, out_bus.probably_prime);
          error_count++;
        end
      end
    end
  end

  initial begin
    directed_row_t        rows[$];
    verdict_rec_t         exp_rec;
    logic [FieldBits-1:0] number;
    logic [FieldBits-1:0] witness;
    logic [FieldBits-1:0] primes[10];
    int unsigned          kind;

    primes = '{32'd5, 32'd7, 32'd13, 32'd101, 32'd65537, 32'd1000000007, 32'd2147483647,
               32'd4294967291, 32'd561, 32'd1105};

    in_bus.valid   = 1'b0;
    in_bus.number  = '0;
    in_bus.witness = '0;
    out_bus.ready  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: small numbers, witness zero and one, witness at or above number,
    // witness equal to number minus one, and full-width values.
    rows = '{
      '{32'd0, 32'd7, 1'b1, VerdictSmallComposite},
      '{32'd1, 32'hFFFFFFFF, 1'b1, VerdictSmallComposite},
      '{32'd2, 32'd0, 1'b1, VerdictSmallPrime},
      '{32'd3, 32'hFFFFFFFF, 1'b1, VerdictSmallPrime},
      '{32'd4, 32'd3, 1'b1, VerdictSmallComposite},
      '{32'd5, 32'd0, 1'b1, VerdictCommonFactor},
      '{32'hFFFFFFFF, 32'd0, 1'b1, VerdictCommonFactor},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, VerdictCommonFactor},
      '{32'd7, 32'd1, 1'b1, VerdictPasses},
      '{32'd9, 32'd1, 1'b1, VerdictPasses},
      '{32'd6, 32'd4, 1'b1, VerdictCommonFactor},
      '{32'd9, 32'd2, 1'b0, VerdictPasses},
      '{32'd15, 32'd14, 1'b0, VerdictPasses},
      '{32'd10, 32'd9, 1'b0, VerdictPasses},
      '{32'd13, 32'd100, 1'b0, VerdictPasses},
      '{32'd561, 32'd2, 1'b0, VerdictPasses},
      '{32'd4294967291, 32'd2, 1'b0, VerdictPasses},
      '{32'd4294967291, 32'hFFFFFFFF, 1'b0, VerdictPasses},
      '{32'd2147483647, 32'd2147483646, 1'b0, VerdictPasses},
      '{32'hFFFFFFFE, 32'hAAAAAAAB, 1'b0, VerdictPasses}
    };
    foreach (rows[i]) begin
      exp_rec = fermat_verdict(rows[i].number, rows[i].witness);
      if (rows[i].known_verdict) begin
        exp_rec.verdict = rows[i].verdict;
        exp_rec.probably_prime = (rows[i].verdict == VerdictSmallPrime ||
                                  rows[i].verdict == VerdictPasses);
      end
      send_candidate(rows[i].number, rows[i].witness, exp_rec);
    end

    // Random part, cycling through the idle and stall phases every 20 items.
    for (int i = 0; i < RandomItems; i++) begin
      case ((i / 20) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      kind = $urandom_range(9);
      if (kind < 4) begin
        // Known primes and Carmichael numbers with a random base in range.
        number = primes[$urandom_range(9)];
        witness = 2 + ($urandom() % (number - 4));
      end else if (kind < 6) begin
        number = $urandom() | 32'd1;
        witness = $urandom();
      end else if (kind < 7) begin
        number = $urandom_range(20);
        witness = $urandom();
      end else begin
        number = $urandom();
        witness = $urandom();
      end
      send_candidate(number, witness, fermat_verdict(number, witness));
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/fpw_pkg.sv
hdl/fpw_if.sv
hdl/fpw_modmul.sv
hdl/fpw_gcd.sv
hdl/fermat_primality_witness_check_core.sv
verif/fermat_primality_witness_check_core_test.sv
